// ===== design/bclcp_pkg.sv =====
// Shared types and constants of the byte-coded LCP decoder.
`timescale 1ns / 1ps
package bclcp_pkg;

  // Store geometry
  localparam int MAX_ROWS    = 4096;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int MAX_ANCHORS = 256;
  localparam int ANC_AW      = $clog2(MAX_ANCHORS);
  localparam int CNT_W       = ANC_AW + 1;
  localparam int GUIDE_BLOCK = 256;
  localparam int GUIDE_SHIFT = $clog2(GUIDE_BLOCK);

  // Field widths
  localparam int WORD_W  = 32;
  localparam int RATE_W  = 16;
  localparam int RCNT_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int BLK_W   = WORD_W - GUIDE_SHIFT;
  localparam int CFG_IW  = 2;

  localparam logic [BYTE_W-1:0] BYTE_LIMIT = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_RATE  = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_TEXT  = 2'd2
  } cfg_idx_e;

  // Item modes
  typedef enum logic [2:0] {
    MODE_WRITE   = 3'd0,
    MODE_APPEND  = 3'd1,
    MODE_EXACT   = 3'd2,
    MODE_ATLEAST = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ROW       = 3'd1,
    ST_NO_ANCHOR = 3'd2,
    ST_MISALIGN  = 3'd3,
    ST_BEYOND    = 3'd4,
    ST_NOCOVER   = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_MOD,
    S_SRCH,
    S_SWAIT,
    S_FETCH,
    S_VAL,
    S_RESP
  } state_e;

  // Remainder unit response
  typedef struct packed {
    logic done;
    logic zero;
  } mod_rsp_t;

endpackage

// ===== design/byte_coded_lcp_decoder_unit.sv =====
// Top level of the byte-coded LCP decoder: sequencer, stores and result register.
//
//   channel   | direction | contents
//   ----------+-----------+---------------------------------------------------
//   s_axis    | in        | tuser: mode; tdata: row, row_byte, position,
//             |           |   anchor_val, target
//   m_axis    | out       | tdata: lcp, at_least, status
//   cfg       | in        | cfg_we_i, cfg_idx_i, cfg_data_i (no read-back)
//
// Writes, appends, clears and rejected items go from idle to the result step and
// then the result register; a query on a plain row byte reads the row store first.
// An overflow row passes through the bit-serial remainder unit, a binary anchor search
// of up to 9 steps, an anchor fetch, a subtraction and the remainder unit once more.
// Reset clears the anchor count and the control state; the row and anchor stores
// hold undefined data until written. A new word is taken only in idle; a result
// still waiting in the output register holds the sequencer in its last step.
`timescale 1ns / 1ps
module byte_coded_lcp_decoder_unit
  import bclcp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // input stream
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [11:0] row, [19:12] row_byte, [51:20] position, [83:52] anchor_val,
  // [115:84] target, [119:116] zero
  input  logic [119:0]  s_axis_tdata_i,
  // [2:0] mode
  input  logic [2:0]    s_axis_tuser_i,
  // result stream
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] lcp, [32] at_least, [35:33] status, [39:36] zero
  output logic [39:0]   m_axis_tdata_o,
  // configuration writes
  input  logic          cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_data_i
);

  // Input field unpack
  logic [ROW_W-1:0]  in_row;
  logic [BYTE_W-1:0] in_byte;
  logic [WORD_W-1:0] in_pos, in_aval, in_target;
  mode_e             in_mode;

  assign in_row    = s_axis_tdata_i[11:0];
  assign in_byte   = s_axis_tdata_i[19:12];
  assign in_pos    = s_axis_tdata_i[51:20];
  assign in_aval   = s_axis_tdata_i[83:52];
  assign in_target = s_axis_tdata_i[115:84];
  assign in_mode   = mode_e'(s_axis_tuser_i);

  // Configuration registers
  logic [RATE_W-1:0] rate_q, rate_eff;
  logic [RCNT_W-1:0] rows_q;
  logic [WORD_W-1:0] text_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_W'(1);
      rows_q <= '0;
      text_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE: rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_ROWS: rows_q <= cfg_data_i[RCNT_W-1:0];
        CFG_TEXT: text_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Zero rate acts as one
  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;

  // Sequencer and datapath registers
  state_e            state_q, state_d;
  logic              qmode_exact_q, qmode_exact_d;
  logic              second_q, second_d;
  logic [WORD_W-1:0] pos_q, pos_d, target_q, target_d;
  logic [WORD_W-1:0] aval_q, aval_d, delta_q, delta_d;
  logic [WORD_W:0]   diff_q, diff_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, cnt_q, cnt_d, mid;
  logic [WORD_W-1:0] lcp_q, lcp_d;
  logic              ge_q, ge_d;
  status_e           status_q, status_d;
  logic              m_valid_q, m_valid_d;
  logic [39:0]       m_data_q, m_data_d;

  // Store and unit connections
  logic                        accept, out_free;
  logic                        prim_we, anc_we, mod_start;
  logic [BYTE_W-1:0]           prim_rdata;
  logic [ANC_AW-1:0]           anc_raddr;
  logic [2*WORD_W-1:0]         anc_rdata;
  logic [WORD_W-1:0]           anc_rpos, anc_rval, mod_dvd;
  logic                        row_ok_wr, row_ok_q, cnt_room, byte_small, guide_fail;
  logic [WORD_W-1:0]           text_m1;
  logic [BLK_W:0]              blocks;
  mod_rsp_t                    mod_rsp;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign row_ok_wr  = ({1'b0, in_row} < RCNT_W'(MAX_ROWS));
  assign row_ok_q   = ({1'b0, in_row} < rows_q) && row_ok_wr;
  assign cnt_room   = (cnt_q < CNT_W'(MAX_ANCHORS));
  assign byte_small = (prim_rdata < BYTE_LIMIT);
  assign mid        = CNT_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign anc_rpos   = anc_rdata[WORD_W-1:0];
  assign anc_rval   = anc_rdata[2*WORD_W-1:WORD_W];

  // Guide range: position block must lie below the block count of the text
  assign text_m1    = text_q - 1'b1;
  assign blocks     = {1'b0, text_m1[WORD_W-1:GUIDE_SHIFT]} + 1'b1;
  assign guide_fail = (text_q == '0) || ({1'b0, pos_q[WORD_W-1:GUIDE_SHIFT]} >= blocks);

  bclcp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_ROWS)
  ) u_prim_ram (
    .clk_i  (clk_i),
    .we_i   (prim_we),
    .waddr_i(in_row),
    .wdata_i(in_byte),
    .raddr_i(in_row),
    .rdata_o(prim_rdata)
  );

  bclcp_ram #(
    .WIDTH(2 * WORD_W),
    .DEPTH(MAX_ANCHORS)
  ) u_anc_ram (
    .clk_i  (clk_i),
    .we_i   (anc_we),
    .waddr_i(cnt_q[ANC_AW-1:0]),
    .wdata_i({in_aval, in_pos}),
    .raddr_i(anc_raddr),
    .rdata_o(anc_rdata)
  );

  bclcp_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(mod_dvd),
    .divisor_i (rate_eff),
    .rsp_o     (mod_rsp)
  );

  // Next state and datapath updates
  always_comb begin
    state_d       = state_q;
    qmode_exact_d = qmode_exact_q;
    second_d      = second_q;
    pos_d         = pos_q;
    target_d      = target_q;
    aval_d        = aval_q;
    delta_d       = delta_q;
    diff_d        = diff_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    cnt_d         = cnt_q;
    lcp_d         = lcp_q;
    ge_d          = ge_q;
    status_d      = status_q;
    m_valid_d     = m_valid_q && !m_axis_tready_i;
    m_data_d      = m_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d         = in_pos;
          target_d      = in_target;
          qmode_exact_d = (in_mode == MODE_EXACT);
          lcp_d         = '0;
          ge_d          = 1'b0;
          status_d      = ST_OK;
          state_d       = S_RESP;
          unique case (in_mode)
            MODE_WRITE: begin
              if (!row_ok_wr) status_d = ST_ROW;
            end
            MODE_APPEND: begin
              if (cnt_room) cnt_d = cnt_q + 1'b1;
              else          status_d = ST_FULL;
            end
            MODE_EXACT, MODE_ATLEAST: begin
              if (row_ok_q) state_d = S_BYTE;
              else          status_d = ST_ROW;
            end
            MODE_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_BYTE: begin
        priority if (byte_small) begin
          if (qmode_exact_q) lcp_d = {{(WORD_W-BYTE_W){1'b0}}, prim_rdata};
          else ge_d = ({{(WORD_W-BYTE_W){1'b0}}, prim_rdata} >= target_q);
          state_d = S_RESP;
        end else if (!qmode_exact_q &&
                     (target_q <= {{(WORD_W-BYTE_W){1'b0}}, BYTE_LIMIT})) begin
          ge_d    = 1'b1;
          state_d = S_RESP;
        end else begin
          second_d = 1'b0;
          state_d  = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_d = S_RESP;
          if (!second_q) begin
            priority if (!mod_rsp.zero) status_d = ST_MISALIGN;
            else if (cnt_q == '0)       status_d = ST_NO_ANCHOR;
            else if (guide_fail)        status_d = ST_BEYOND;
            else begin
              lo_d    = '0;
              hi_d    = cnt_q;
              state_d = S_SRCH;
            end
          end else begin
            if (!mod_rsp.zero || diff_q[WORD_W] ||
                (diff_q[WORD_W-1:0] < {{(WORD_W-BYTE_W){1'b0}}, BYTE_LIMIT})) begin
              status_d = ST_NOCOVER;
            end else if (qmode_exact_q) begin
              lcp_d = diff_q[WORD_W-1:0];
            end else begin
              ge_d = (diff_q[WORD_W-1:0] >= target_q);
            end
          end
        end
      end
      S_SRCH: begin
        priority if (lo_q < hi_q) state_d = S_SWAIT;
        else if (lo_q == '0) begin
          status_d = ST_NO_ANCHOR;
          state_d  = S_RESP;
        end else state_d = S_FETCH;
      end
      S_SWAIT: begin
        if (pos_q < anc_rpos) hi_d = mid;
        else                  lo_d = mid + 1'b1;
        state_d = S_SRCH;
      end
      S_FETCH: begin
        if (anc_rpos > pos_q) begin
          status_d = ST_NOCOVER;
          state_d  = S_RESP;
        end else begin
          delta_d = pos_q - anc_rpos;
          aval_d  = anc_rval;
          state_d = S_VAL;
        end
      end
      S_VAL: begin
        diff_d   = {1'b0, aval_q} - {1'b0, delta_q};
        second_d = 1'b1;
        state_d  = S_MOD;
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'd0, status_q, ge_q, lcp_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake, store and unit controls
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    prim_we   = 1'b0;
    anc_we    = 1'b0;
    mod_start = 1'b0;
    mod_dvd   = pos_q;
    anc_raddr = (lo_q < hi_q) ? mid[ANC_AW-1:0] : ANC_AW'(lo_q - 1'b1);
    unique case (state_q)
      S_IDLE: begin
        prim_we = accept && (in_mode == MODE_WRITE) && row_ok_wr;
        anc_we  = accept && (in_mode == MODE_APPEND) && cnt_room;
      end
      S_BYTE: begin
        mod_start = !byte_small &&
                    (qmode_exact_q ||
                     (target_q > {{(WORD_W-BYTE_W){1'b0}}, BYTE_LIMIT}));
      end
      S_VAL: begin
        mod_start = 1'b1;
        mod_dvd   = delta_q;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      second_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      second_q  <= second_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    qmode_exact_q <= qmode_exact_d;
    pos_q         <= pos_d;
    target_q      <= target_d;
    aval_q        <= aval_d;
    delta_q       <= delta_d;
    diff_q        <= diff_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    lcp_q         <= lcp_d;
    ge_q          <= ge_d;
    status_q      <= status_d;
    m_data_q      <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== design/bclcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bclcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bclcp_mod.sv =====
// Bit-serial remainder unit: tests a 32-bit word against the sampling rate.
`timescale 1ns / 1ps
module bclcp_mod
  import bclcp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output mod_rsp_t          rsp_o
);

  localparam int STEP_W = $clog2(WORD_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [WORD_W-1:0] dvd_q;
  logic [RATE_W-1:0] div_q, rem_q, rem_d;
  logic [RATE_W:0]   trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[WORD_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = RATE_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[RATE_W-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(WORD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule
